// ----- rtl/core/cjd_pkg.sv -----
`default_nettype none
package cjd_pkg;

  // Field widths
  localparam int YEAR_W   = 15;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int JD_W     = 40;

  // Internal widths
  localparam int DN_W   = 25;  // day number, signed
  localparam int KEY_W  = 24;  // calendar switch key, signed
  localparam int SECS_W = 17;  // seconds of day
  localparam int VF_W   = 22;  // (secs*125 + 53) / 4
  localparam int FRAC_W = 18;  // day fraction in 1e-5 day
  localparam int SUM_W  = 43;  // full result before saturation

  typedef logic signed [DN_W-1:0] dn_t;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  localparam logic signed [DN_W-1:0]  EPOCH_OFFSET = 25'sd1720995;
  localparam logic signed [KEY_W-1:0] GREG_START_KEY = 24'sd588829;

  // floor(y/100) via offset y + 16400 (nonnegative), then reciprocal multiply
  localparam logic [15:0] CENT_OFFSET = 16'd16400;
  localparam logic [9:0]  CENT_BIAS   = 10'd164;
  localparam logic [31:0] CENT_RECIP  = 32'd41944;  // ceil(2^22 / 100)
  localparam int          CENT_SHIFT  = 22;

  // floor(w/27) for w < 2^22, reciprocal ceil(2^27 / 27)
  localparam logic [22:0] FRAC_RECIP = 23'd4971027;
  localparam int          FRAC_SHIFT = 27;

  localparam logic signed [SUM_W-1:0] UNITS_PER_DAY = 43'sd100000;
  localparam logic signed [SUM_W-1:0] HALF_DAY      = 43'sd50000;
  localparam logic signed [SUM_W-1:0] JD_MAX        = 43'sd549755813887;
  localparam logic signed [SUM_W-1:0] JD_MIN        = -43'sd549755813888;

  // floor(30.6001 * m) for the shifted month m
  function automatic logic [8:0] month_days(input logic [4:0] m);
    logic [8:0] d;
    case (m)
      5'd4:    d = 9'd122;
      5'd5:    d = 9'd153;
      5'd6:    d = 9'd183;
      5'd7:    d = 9'd214;
      5'd8:    d = 9'd244;
      5'd9:    d = 9'd275;
      5'd10:   d = 9'd306;
      5'd11:   d = 9'd336;
      5'd12:   d = 9'd367;
      5'd13:   d = 9'd397;
      5'd14:   d = 9'd428;
      5'd15:   d = 9'd459;
      5'd16:   d = 9'd489;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/calendar_to_julian_date.sv -----
`default_nettype none
// Julian date (units of 1e-5 day) from a calendar date and time.
// The result is registered in stage 1, stage 2 and the output register after input transfer.
// Throughput: one item per cycle; each stage holds one item and moves on
// as soon as the stage after it has room.
// Reset (rst, synchronous): all stage valid bits clear; payload is not reset.
module calendar_to_julian_date (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [cjd_pkg::YEAR_W-1:0]     year,
  input  wire logic        [cjd_pkg::MONTH_W-1:0]    month,
  input  wire logic        [cjd_pkg::DAY_W-1:0]      day,
  input  wire logic        [cjd_pkg::HOUR_W-1:0]     hour,
  input  wire logic        [cjd_pkg::MINUTE_W-1:0]   minute,
  input  wire logic        [cjd_pkg::SECOND_W-1:0]   second,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [cjd_pkg::JD_W-1:0]            julian_date_e5
);
  import cjd_pkg::*;

  // Stage handshake
  logic v1, v2;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // ---------------- Stage 0: from input ports ----------------
  logic signed [15:0]       y0;
  logic        [4:0]        m0;
  logic signed [26:0]       yd0;
  dn_t                      base0;
  logic signed [KEY_W-1:0]  yr0, mkey0, key0;
  logic                     greg0;
  logic        [15:0]       u0;
  logic        [31:0]       cprod0;
  logic        [SECS_W-1:0] secs0;
  logic        [23:0]       vsum0;

  // Jan/Feb belong to the previous year
  always_comb begin
    if (month > MONTH_FEB) begin
      y0 = 16'(year);
      m0 = {1'b0, month} + 5'd1;
    end else begin
      y0 = 16'(year) - 16'sd1;
      m0 = {1'b0, month} + 5'd13;
    end
  end

  // Day number before the century correction
  assign yd0   = 27'(y0) * 27'sd1461;
  assign base0 = yd0[26:2] + $signed({16'd0, month_days(m0)})
               + $signed({20'd0, day}) + EPOCH_OFFSET;

  // Calendar switch test on raw year, month and day
  assign yr0   = KEY_W'(year);
  assign mkey0 = yr0 * 24'sd12 + $signed({20'd0, month});
  assign key0  = mkey0 * 24'sd31 + $signed({19'd0, day});
  assign greg0 = key0 >= GREG_START_KEY;

  // Century count, offset to stay nonnegative
  assign u0     = y0 + CENT_OFFSET;
  assign cprod0 = {16'd0, u0} * CENT_RECIP;

  // Day fraction numerator, rounded half down
  assign secs0 = {12'd0, hour} * 17'd3600 + {11'd0, minute} * 17'd60
               + {11'd0, second};
  assign vsum0 = {7'd0, secs0} * 24'd125 + 24'd53;

  dn_t              s1_base;
  logic             s1_greg;
  logic [8:0]       s1_q;
  logic [VF_W-1:0]  s1_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_base <= base0;
      s1_greg <= greg0;
      s1_q    <= cprod0[CENT_SHIFT+8:CENT_SHIFT];
      s1_w    <= vsum0[23:2];
    end
  end

  // ---------------- Stage 1: correction and fraction ----------------
  logic signed [9:0]  a1, corr1;
  dn_t                dn1;
  logic        [44:0] fprod1;

  assign a1     = $signed({1'b0, s1_q}) - $signed(CENT_BIAS);
  assign corr1  = 10'sd2 - a1 + (a1 >>> 2);
  assign dn1    = s1_greg ? (s1_base + DN_W'(corr1)) : s1_base;
  assign fprod1 = {23'd0, s1_w} * {22'd0, FRAC_RECIP};

  dn_t               s2_dn;
  logic [FRAC_W-1:0] s2_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_dn   <= dn1;
      s2_frac <= fprod1[FRAC_SHIFT+FRAC_W-1:FRAC_SHIFT];
    end
  end

  // ---------------- Stage 2: scale, noon shift, saturate ----------------
  logic signed [SUM_W-1:0] full2;
  logic signed [JD_W-1:0]  jd_next;

  assign full2 = SUM_W'(s2_dn) * UNITS_PER_DAY
               + $signed({25'd0, s2_frac}) - HALF_DAY;

  always_comb begin
    if (full2 > JD_MAX) begin
      jd_next = JD_MAX[JD_W-1:0];
    end else if (full2 < JD_MIN) begin
      jd_next = JD_MIN[JD_W-1:0];
    end else begin
      jd_next = full2[JD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      julian_date_e5 <= jd_next;
    end
  end

endmodule
`default_nettype wire
